/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms on aclk, with reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every aclk edge outside reset.
`define UPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that trig implies cons in the next cycle, outside reset.
`define UPC_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cons)) else $error(msg);

`endif

/* sv/upc_pkg.sv */
// ----------------------------------------------------------------------------
// URL percent codec package
// Mode codes, result set types and character helpers.
// ----------------------------------------------------------------------------
package upc_pkg;

    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_ENC  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;

    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_PCT  = 2'd1;
    localparam logic [1:0] ESC_HIGH = 2'd2;

    localparam int unsigned MaxRes = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } res_word_t;

    typedef struct packed {
        logic [1:0] cnt;
        res_word_t  w2;
        res_word_t  w1;
        res_word_t  w0;
    } res_set_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib > 4'd9) ? ({4'd0, nib} + 8'd55) : ({4'd0, nib} + 8'd48);
    endfunction

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= "A" && c <= "Z") begin
                d = c - 8'd55;
            end else if (c >= "a" && c <= "z") begin
                d = c - 8'd87;
            end else if (c >= "0" && c <= "9") begin
                d = c - 8'd48;
            end
            digit_value = d[5:0];
        end
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        is_unreserved = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                        (c >= "0" && c <= "9") || c == "-" || c == "_" ||
                        c == "." || c == "~";
    endfunction

    function automatic res_word_t mk_word(input logic [7:0] data, input logic has,
                                          input logic last);
        res_word_t w;
        begin
            w.data     = data;
            w.has_byte = has;
            w.last     = last;
            mk_word    = w;
        end
    endfunction

endpackage

/* sv/upc_xform.sv */
// ----------------------------------------------------------------------------
// URL codec transform stage
// Input word register, mode register, escape state and per-word translation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upc_xform (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              buf_free,
    output logic              load,
    output upc_pkg::res_set_t res_set
);
    import upc_pkg::*;

    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic [1:0] mode_reg;
    logic [1:0] phase_reg, phase_next;
    logic [5:0] hi_reg, hi_next;
    logic [5:0] dv;
    logic [7:0] esc_val;

    assign load     = in_vld_reg && buf_free;
    assign s_tready = !in_vld_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            mode_reg   <= MODE_PASS;
            phase_reg  <= ESC_IDLE;
            hi_reg     <= 6'd0;
        end else begin
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                in_vld_reg <= 1'b1;
            end else if (load) begin
                in_vld_reg <= 1'b0;
            end
            if (load) begin
                phase_reg <= phase_next;
                hi_reg    <= hi_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    assign dv      = digit_value(in_byte_reg);
    assign esc_val = {hi_reg[3:0], 4'd0} + {2'd0, dv};

    always_comb begin
        res_set    = '0;
        phase_next = ESC_IDLE;
        hi_next    = 6'd0;
        res_set.cnt = 2'd1;
        res_set.w0  = mk_word(in_byte_reg, 1'b1, in_last_reg);
        case (mode_reg)
            MODE_ENC: begin
                if (is_unreserved(in_byte_reg)) begin
                    res_set.w0 = mk_word(in_byte_reg, 1'b1, in_last_reg);
                end else if (in_byte_reg == " ") begin
                    res_set.w0 = mk_word("+", 1'b1, in_last_reg);
                end else begin
                    res_set.cnt = 2'd3;
                    res_set.w0  = mk_word("%", 1'b1, 1'b0);
                    res_set.w1  = mk_word(hex_char(in_byte_reg[7:4]), 1'b1, 1'b0);
                    res_set.w2  = mk_word(hex_char(in_byte_reg[3:0]), 1'b1, in_last_reg);
                end
            end
            MODE_DEC: begin
                if (phase_reg == ESC_PCT) begin
                    if (in_last_reg) begin
                        res_set.w0 = mk_word(8'd0, 1'b0, 1'b1);
                    end else begin
                        res_set.cnt = 2'd0;
                        phase_next  = ESC_HIGH;
                        hi_next     = dv;
                    end
                end else if (phase_reg == ESC_HIGH) begin
                    res_set.w0 = mk_word(esc_val, 1'b1, in_last_reg);
                end else if (in_byte_reg == "+") begin
                    res_set.w0 = mk_word(" ", 1'b1, in_last_reg);
                end else if (in_byte_reg == "%") begin
                    if (in_last_reg) begin
                        // string ends on the percent sign: bare end mark
                        res_set.w0 = mk_word(8'd0, 1'b0, 1'b1);
                    end else begin
                        res_set.cnt = 2'd0;
                        phase_next  = ESC_PCT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    `UPC_ASSERT(a_phase_legal, phase_reg != 2'd3, "escape phase reached unused code")
    `UPC_ASSERT_NEXT(a_nondec_clears, load && mode_reg != MODE_DEC,
                     phase_reg == ESC_IDLE, "escape not cleared outside decode")
    `UPC_ASSERT_NEXT(a_last_clears, load && in_last_reg,
                     phase_reg == ESC_IDLE, "escape survives end of string")

endmodule

/* sv/upc_out_buf.sv */
// ----------------------------------------------------------------------------
// URL codec result buffer
// Holds up to three result words per input, sends one per cycle if m_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upc_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  upc_pkg::res_set_t res_set,
    output logic              buf_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser,
    output logic              m_tlast
);
    import upc_pkg::*;

    res_word_t  ent_reg [MaxRes];
    logic [1:0] rem_reg;
    logic [1:0] pos_reg;
    logic       emit;
    res_word_t  cur;

    assign m_tvalid = (rem_reg != 2'd0);
    assign emit     = m_tvalid && m_tready;
    assign buf_free = (rem_reg == 2'd0) || (rem_reg == 2'd1 && m_tready);
    assign cur      = ent_reg[pos_reg];
    assign m_tdata  = cur.data;
    assign m_tuser  = cur.has_byte;
    assign m_tlast  = cur.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
            pos_reg <= 2'd0;
        end else if (load) begin
            rem_reg <= res_set.cnt;
            pos_reg <= 2'd0;
        end else if (emit) begin
            rem_reg <= rem_reg - 2'd1;
            pos_reg <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ent_reg[0] <= res_set.w0;
            ent_reg[1] <= res_set.w1;
            ent_reg[2] <= res_set.w2;
        end
    end

    `UPC_ASSERT(a_no_overwrite, !load || rem_reg == 2'd0 || (rem_reg == 2'd1 && m_tready),
                "result buffer loaded while words remain")
    `UPC_ASSERT(a_pos_range, !m_tvalid || (pos_reg + rem_reg <= 3'd3),
                "result position past buffer end")

endmodule

/* sv/url_percent_codec_core.sv */
// ----------------------------------------------------------------------------
// URL percent codec core
// Byte-stream passthrough / URL encode / URL decode with stream handshakes.
// ----------------------------------------------------------------------------
//  channel | dir | tdata          | tuser     | tlast
//  s_      | in  | [7:0] in_byte  | -         | in_last
//  m_      | out | [7:0] out_byte | [0] has_byte | out_last
//  cfg_    | in  | [1:0] mode     | -         | -
//
//  One input word is taken per cycle while s_tready is high; the result
//  buffer sends one word per cycle while m_tready is high. An encoded escape
//  gives three result words, all other words one (none for escape digits
//  still pending). Path: input register, then result buffer.
//  Reset (aresetn low, synchronous) clears mode, escape state and valids.
//  A stall on m_ holds the buffer; s_tready drops once the input register
//  also holds a word that cannot move on.
// ----------------------------------------------------------------------------
module url_percent_codec_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,  // mode: 0 pass, 1 encode, 2 decode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [0:0] m_tuser,    // [0] has_byte
    output logic       m_tlast     // out_last
);
    import upc_pkg::*;

    logic     load;
    logic     buf_free;
    res_set_t res_set;

    // translation stage: input register, mode and escape state
    upc_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .buf_free  (buf_free),
        .load      (load),
        .res_set   (res_set)
    );

    // result buffer: serializes up to three words per input word
    upc_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .res_set  (res_set),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// URL percent codec testbench
// Runs directed and random byte strings through every mode, with random
// idling on both stream sides, and checks each result word against a local
// predictor of the codec.
// ----------------------------------------------------------------------------
module tb;
    import upc_pkg::*;

    // Mode 3 is unused by the codec and must behave as passthrough.
    localparam logic [1:0] MODE_RSVD = 2'd3;

    // Extra wait after a drain, with a little margin.
    localparam int DRAIN_CYCLES   = 6;
    // Longest legal silence: the receiver hold-off plus long
    // random stall runs, taken several times over.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    // ------------------------------------------------------------------
    // DUT signals, tb-driven ones known from time zero
    // ------------------------------------------------------------------
    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [1:0] cfg_wdata = 2'd0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'd0;   // [7:0] in_byte
    logic       s_tlast   = 1'b0;   // in_last
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic [0:0] m_tuser;            // [0] has_byte
    logic       m_tlast;            // out_last

    url_percent_codec_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of mode and the decode escape tracker
    // ------------------------------------------------------------------
    logic [1:0] codec_mode  = MODE_PASS;
    logic [1:0] esc_state   = ESC_IDLE;
    logic [5:0] esc_hi      = 6'd0;

    res_word_t  pending_words[$];   // result words still owed by the codec

    int         fail_count   = 0;
    int         words_sent   = 0;
    int         idle_streak  = 0;
    int         tx_idle_pct  = 0;   // sender idle chance per cycle
    int         rx_stall_pct = 0;   // receiver stall chance per cycle
    logic       rx_hold      = 1'b0; // forces a long receiver hold-off

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Character helpers for the predictor
    // ------------------------------------------------------------------
    function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
        if (n < 4'd10) begin
            return "0" + {4'd0, n};
        end
        return "A" + {4'd0, n} - 8'd10;
    endfunction

    // Escape digit weight: 0-9, letters of either case 10-35, else 0.
    function automatic logic [5:0] char_weight(input logic [7:0] c);
        logic [7:0] w;
        w = 8'd0;
        if (c >= "0" && c <= "9") begin
            w = c - "0";
        end else if (c >= "A" && c <= "Z") begin
            w = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "z") begin
            w = c - "a" + 8'd10;
        end
        return w[5:0];
    endfunction

    function automatic logic is_plain_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == "-" || c == "_" ||
               c == "." || c == "~";
    endfunction

    function automatic void owe_word(input logic [7:0] d, input logic has,
                                     input logic lst);
        res_word_t w;
        w.data     = d;
        w.has_byte = has;
        w.last     = lst;
        pending_words.push_back(w);
    endfunction

    // Works out the result words for one accepted input word.
    function automatic void predict_codec(input logic [7:0] b, input logic lst);
        logic [9:0] esc_val;
        case (codec_mode)
            MODE_ENC: begin
                esc_state = ESC_IDLE;
                esc_hi    = 6'd0;
                if (is_plain_char(b)) begin
                    owe_word(b, 1'b1, lst);
                end else if (b == " ") begin
                    owe_word("+", 1'b1, lst);
                end else begin
                    owe_word("%", 1'b1, 1'b0);
                    owe_word(nibble_ascii(b[7:4]), 1'b1, 1'b0);
                    owe_word(nibble_ascii(b[3:0]), 1'b1, lst);
                end
            end
            MODE_DEC: begin
                if (esc_state == ESC_PCT) begin
                    esc_hi = char_weight(b);
                    if (lst) begin
                        // string ends on the high digit: escape dropped
                        esc_state = ESC_IDLE;
                        esc_hi    = 6'd0;
                        owe_word(8'd0, 1'b0, 1'b1);
                    end else begin
                        esc_state = ESC_HIGH;
                    end
                end else if (esc_state == ESC_HIGH) begin
                    esc_val   = {esc_hi, 4'd0} + {4'd0, char_weight(b)};
                    esc_state = ESC_IDLE;
                    esc_hi    = 6'd0;
                    owe_word(esc_val[7:0], 1'b1, lst);
                end else begin
                    esc_state = ESC_IDLE;
                    esc_hi    = 6'd0;
                    if (b == "+") begin
                        owe_word(" ", 1'b1, lst);
                    end else if (b == "%") begin
                        if (lst) begin
                            owe_word(8'd0, 1'b0, 1'b1);
                        end else begin
                            esc_state = ESC_PCT;
                        end
                    end else begin
                        owe_word(b, 1'b1, lst);
                    end
                end
            end
            default: begin
                // passthrough and the unused mode value
                esc_state = ESC_IDLE;
                esc_hi    = 6'd0;
                owe_word(b, 1'b1, lst);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, or a forced hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        res_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual data=%h has=%b last=%b",
                         $time, m_tdata, m_tuser[0], m_tlast);
                fail_count = fail_count + 1;
            end else begin
                want = pending_words.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: out_byte mismatch: expected %h actual %h",
                             $time, want.data, m_tdata);
                    fail_count = fail_count + 1;
                end
                if (m_tuser[0] !== want.has_byte) begin
                    $display("%0t: has_byte mismatch: expected %b actual %b",
                             $time, want.has_byte, m_tuser[0]);
                    fail_count = fail_count + 1;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: out_last mismatch: expected %b actual %b",
                             $time, want.last, m_tlast);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no handshake on either side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_streak <= 0;
        end else begin
            idle_streak <= idle_streak + 1;
        end
        if (idle_streak >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_streak);
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offers one word, optionally after a random gap, and waits for the
    // handshake. tvalid stays high on return so back-to-back words flow.
    task automatic send_word(input logic [7:0] b, input logic lst);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) begin
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_codec(b, lst);
        words_sent = words_sent + 1;
    endtask

    task automatic send_string(input logic [7:0] str[$]);
        foreach (str[i]) begin
            send_word(str[i], i == str.size() - 1);
        end
    endtask

    // Sender goes quiet until every owed word has been taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Mode writes only with the codec idle; an escape digit leaves no
    // owed word, so give the pipeline a few extra cycles.
    task automatic set_mode(input logic [1:0] m);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        codec_mode = m;
    endtask

    function automatic logic [7:0] rand_hex_digit();
        logic [3:0] n;
        logic [7:0] c;
        n = 4'($urandom_range(15));
        c = nibble_ascii(n);
        if (n > 4'd9 && $urandom_range(1) == 1) begin
            c = c + 8'd32;  // lowercase
        end
        return c;
    endfunction

    // Random string in the current mode. Decode gets mostly well-formed
    // escapes with random digits, plus stray '%' and '+' and raw bytes.
    task automatic send_random_string();
        logic [7:0] str[$];
        logic [7:0] c;
        int         len;
        int         sel;
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
        while (str.size() < len) begin
            sel = $urandom_range(9);
            if (codec_mode == MODE_DEC && sel < 4) begin
                str.push_back("%");
                str.push_back(rand_hex_digit());
                str.push_back(rand_hex_digit());
            end else if (sel < 6) begin
                c = 8'($urandom_range(32, 126));
                str.push_back(c);
            end else if (sel == 6) begin
                str.push_back("+");
            end else if (sel == 7) begin
                str.push_back("%");
            end else begin
                c = 8'($urandom);
                str.push_back(c);
            end
        end
        // occasionally cut the tail, which can break an escape
        if (str.size() > 1 && $urandom_range(7) == 0) begin
            void'(str.pop_back());
        end
        send_string(str);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_passthrough();
        set_mode(MODE_PASS);
        send_string('{8'h00, 8'hFF});
    endtask

    // plain chars, space, and escaped bytes at both extremes
    task automatic test_encode();
        set_mode(MODE_ENC);
        send_string('{"~", "a", " "});
        send_string('{8'h00, "%", 8'hFF});
    endtask

    // '+', escapes with digits of both cases, a '+' used as a digit,
    // strings ending on '%' and on the high digit ('%' taken as a digit)
    task automatic test_decode();
        set_mode(MODE_DEC);
        send_string('{"+", "%", "4", "+"});
        send_string('{"%", "z", "Z"});
        send_string('{"%"});
        send_string('{"%", "%"});
    endtask

    task automatic test_reserved_mode();
        set_mode(MODE_RSVD);
        send_string('{"%"});
    endtask

    // A pending escape is cleared by a word in another mode.
    task automatic test_mode_switch_mid_escape();
        set_mode(MODE_DEC);
        send_word("%", 1'b0);
        set_mode(MODE_ENC);
        send_word("A", 1'b0);
        set_mode(MODE_DEC);
        send_word("1", 1'b1);
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input int n_words);
        int         start;
        int         pick;
        logic [1:0] m;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        start        = words_sent;
        while (words_sent - start < n_words) begin
            pick = $urandom_range(5);
            case (pick)
                0:       m = MODE_PASS;
                1:       m = MODE_ENC;
                2:       m = MODE_ENC;
                5:       m = MODE_RSVD;
                default: m = MODE_DEC;
            endcase
            set_mode(m);
            repeat ($urandom_range(2, 5)) send_random_string();
        end
    endtask

    // Receiver holds off while the sender keeps offering encoded bytes,
    // so the result buffer fills and s_tready drops; then the sender
    // waits for a full drain before more traffic.
    task automatic test_backpressure();
        logic [7:0] b;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        set_mode(MODE_ENC);
        fork
            begin
                rx_hold = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_hold = 1'b0;
            end
            begin
                repeat (24) begin
                    b = 8'($urandom);
                    send_word(b, $urandom_range(3) == 0);
                end
            end
        join
        drain_results();
        set_mode(MODE_DEC);
        repeat (3) send_random_string();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_passthrough();
        test_encode();
        test_decode();
        test_reserved_mode();
        test_mode_switch_mid_escape();

        test_random_traffic(0, 0, 70);
        test_random_traffic(78, 0, 70);
        test_random_traffic(0, 78, 70);
        test_random_traffic(22, 22, 70);
        test_backpressure();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
